// ===== design/pbwe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbwe_pkg
// Shared types and constants of the protobuf wire encoder.
// ----------------------------------------------------------------------------
package pbwe_pkg;

    localparam int OP_W       = 3;
    localparam int VAL_W      = 64;
    localparam int FIELD_W    = 29;
    localparam int WT_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int KEY_W      = FIELD_W + WT_W;
    localparam int GROUP_BITS = 7;
    localparam int FIX32_W    = 32;

    localparam logic [WT_W-1:0] WT_LEN_DELIM = 3'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_VARINT  = 3'd0,
        OP_TAG     = 3'd1,
        OP_FIXED32 = 3'd2,
        OP_BOOL    = 3'd3,
        OP_HEADER  = 3'd4,
        OP_RAW     = 3'd5
    } t_op;

    // How the back end walks the value field
    typedef enum logic [1:0] {
        M_VARINT = 2'd0,
        M_FIXED  = 2'd1,
        M_SINGLE = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic             key_en;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_job;

endpackage

// ===== design/pbwe_ifs.sv =====
// ----------------------------------------------------------------------------
// pbwe_ifs
// Request and byte channels of the protobuf wire encoder.
// ----------------------------------------------------------------------------
interface pbwe_req_if import pbwe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VAL_W-1:0]   item_value;
    logic [FIELD_W-1:0] field_number;
    logic [WT_W-1:0]    wire_kind;

    modport source (output valid, operation, item_value, field_number, wire_kind,
                    input ready);
    modport sink   (input valid, operation, item_value, field_number, wire_kind,
                    output ready);
endinterface

interface pbwe_byte_if import pbwe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== design/pbwe_front.sv =====
// ----------------------------------------------------------------------------
// pbwe_front
// Accepts requests and turns each defined one into a job for the byte engine.
// ----------------------------------------------------------------------------
module pbwe_front import pbwe_pkg::*; (
    pbwe_req_if.sink i_req,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic op_ok;

    always_comb begin
        op_ok        = 1'b1;
        o_job.mode   = M_VARINT;
        o_job.key_en = 1'b0;
        o_job.key    = {i_req.field_number, i_req.wire_kind};
        o_job.value  = i_req.item_value;
        case (i_req.operation)
            OP_VARINT: begin
                o_job.mode = M_VARINT;
            end
            OP_TAG: begin
                o_job.value = {{(VAL_W-KEY_W){1'b0}}, i_req.field_number, i_req.wire_kind};
            end
            OP_FIXED32: begin
                o_job.mode  = M_FIXED;
                o_job.value = {{(VAL_W-FIX32_W){1'b0}}, i_req.item_value[FIX32_W-1:0]};
            end
            OP_BOOL: begin
                o_job.mode  = M_SINGLE;
                o_job.value = {{(VAL_W-1){1'b0}}, |i_req.item_value};
            end
            OP_HEADER: begin
                o_job.key_en = 1'b1;
                o_job.key    = {i_req.field_number, WT_LEN_DELIM};
            end
            OP_RAW: begin
                o_job.mode  = M_SINGLE;
                o_job.value = {{(VAL_W-BYTE_W){1'b0}}, i_req.item_value[BYTE_W-1:0]};
            end
            default: begin
                op_ok = 1'b0;   // undefined op: taken, nothing emitted
            end
        endcase
    end

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full && op_ok;

endmodule

// ===== design/pbwe_queue.sv =====
// ----------------------------------------------------------------------------
// pbwe_queue
// Small job queue between the classifier and the byte engine.
// ----------------------------------------------------------------------------
module pbwe_queue import pbwe_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_job          r_mem [P_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/pbwe_back.sv =====
// ----------------------------------------------------------------------------
// pbwe_back
// Byte engine: walks one job and emits its wire bytes, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module pbwe_back import pbwe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_job         i_job,
    output logic         o_pop,
    pbwe_byte_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_KEY  = 2'd1,
        S_BODY = 2'd2
    } t_state;

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [1:0]        r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic adv;
    logic key_more;
    logic val_more;

    assign adv      = !r_out_valid || o_out.ready;
    assign key_more = |r_key[KEY_W-1:GROUP_BITS];
    assign val_more = |r_val[VAL_W-1:GROUP_BITS];
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_mode  = i_job.mode;
                    n_key   = i_job.key;
                    n_val   = i_job.value;
                    n_cnt   = '0;
                    n_state = i_job.key_en ? S_KEY : S_BODY;
                end
            end
            S_KEY: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {key_more, r_key[GROUP_BITS-1:0]};
                    n_out_last  = 1'b0;     // header length always follows
                    if (key_more) begin
                        n_key = r_key >> GROUP_BITS;
                    end else begin
                        n_state = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    case (r_mode)
                        M_VARINT: begin
                            n_out_byte = {val_more, r_val[GROUP_BITS-1:0]};
                            n_out_last = !val_more;
                            if (val_more) begin
                                n_val = r_val >> GROUP_BITS;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        M_FIXED: begin
                            n_out_byte = r_val[BYTE_W-1:0];
                            n_out_last = &r_cnt;
                            n_val      = r_val >> BYTE_W;
                            n_cnt      = r_cnt + 1'b1;
                            if (&r_cnt) begin
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_out_byte = r_val[BYTE_W-1:0];
                            n_out_last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_val      <= n_val;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

endmodule

// ===== design/protobuf_wire_encoder.sv =====
// ----------------------------------------------------------------------------
// protobuf_wire_encoder
// Encodes varint, tag, fixed32, bool, length header and raw byte requests
// into protobuf wire bytes, last byte of each request marked.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  i_req    in   operation, item_value, field_number, wire_kind   valid/ready
//  o_byte   out  out_byte, last_byte                              valid/ready
//
//  A request is loaded into the byte engine, which then emits its output bytes
//  (1 to 15) one per cycle while not stalled; the byte engine sets the rate.
//  The classifier takes a request each cycle while the job queue has room.
//  Output backpressure stalls only the byte engine; undefined ops are taken
//  and dropped. Synchronous active-low reset empties queue and output.
// ----------------------------------------------------------------------------
module protobuf_wire_encoder import pbwe_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbwe_req_if.sink    i_req,
    pbwe_byte_if.source o_byte
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    pbwe_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    pbwe_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    pbwe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .o_out     (o_byte)
    );

endmodule

// ===== tb/protobuf_wire_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_wire_encoder_test
// Drives encode requests into the wire encoder and checks every output byte
// and its last-byte flag against table bytes or a local wire-format encoder.
// A directed table covers the corner cases first, then random requests follow
// with random gaps on the request side and random stalls on the byte side.
// ----------------------------------------------------------------------------
module protobuf_wire_encoder_test;
    import pbwe_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM     = 100;
    localparam int MAX_BYTES    = 15;
    localparam int PREDICT      = -1;

    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_wire_byte;

    // n_known bytes of known, byte 0 in the low bits; PREDICT uses the encoder
    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic [VAL_W-1:0]            value;
        logic [FIELD_W-1:0]          field;
        logic [WT_W-1:0]             wt;
        int                          n_known;
        logic [MAX_BYTES*BYTE_W-1:0] known;
    } t_row;

    localparam int N_DIRECTED = 23;

    t_row dir_rows [N_DIRECTED] = '{
        '{OP_VARINT,   64'd0,                  29'd0,          3'd0, 1,  120'h00},
        '{OP_VARINT,   64'd127,                29'd0,          3'd0, 1,  120'h7F},
        '{OP_VARINT,   64'd128,                29'd0,          3'd0, 2,  120'h01_80},
        '{OP_VARINT,   64'd300,                29'd0,          3'd0, 2,  120'h02_AC},
        '{OP_VARINT,   64'hFFFF_FFFF_FFFF_FFFF, 29'h1FFF_FFFF, 3'd7, 10,
          120'h01_FFFF_FFFF_FFFF_FFFF_FF},
        '{OP_VARINT,   64'h8000_0000_0000_0000, 29'd0,         3'd0, PREDICT, '0},
        '{OP_TAG,      64'hFFFF_FFFF_FFFF_FFFF, 29'd1,         3'd0, 1,  120'h08},
        '{OP_TAG,      64'd0,                  29'h1FFF_FFFF,  3'd7, 5,  120'h0F_FFFF_FFFF},
        '{OP_TAG,      64'd0,                  29'd0,          3'd0, 1,  120'h00},
        '{OP_TAG,      64'd0,                  29'd16,         3'd5, PREDICT, '0},
        '{OP_FIXED32,  64'hDEAD_BEEF_1234_5678, 29'd0,         3'd0, 4,  120'h1234_5678},
        '{OP_FIXED32,  64'h0000_0000_FFFF_FFFF, 29'd0,         3'd0, 4,  120'hFFFF_FFFF},
        '{OP_FIXED32,  64'hFFFF_FFFF_0000_0000, 29'd0,         3'd0, 4,  120'h0000_0000},
        '{OP_BOOL,     64'd0,                  29'd0,          3'd0, 1,  120'h00},
        '{OP_BOOL,     64'd1,                  29'd0,          3'd0, 1,  120'h01},
        '{OP_BOOL,     64'h8000_0000_0000_0000, 29'd0,         3'd0, 1,  120'h01},
        '{OP_HEADER,   64'd0,                  29'd1,          3'd5, 2,  120'h00_0A},
        '{OP_HEADER,   64'hFFFF_FFFF_FFFF_FFFF, 29'h1FFF_FFFF, 3'd0, 15,
          120'h01_FFFF_FFFF_FFFF_FFFF_FF_0F_FFFF_FFFA},
        '{OP_HEADER,   64'd300,                29'd3,          3'd7, PREDICT, '0},
        '{OP_RAW,      64'hFFFF_FFFF_FFFF_FFAB, 29'd0,         3'd0, 1,  120'hAB},
        '{OP_RAW,      64'h0123_4567_89AB_CD00, 29'd0,         3'd0, 1,  120'h00},
        '{OP_UNDEF_LO, 64'd5,                  29'd1,          3'd1, 0,  '0},
        '{OP_UNDEF_HI, 64'hFFFF_FFFF_FFFF_FFFF, 29'h1FFF_FFFF, 3'd7, 0,  '0}
    };

    logic clk;
    logic rst_n;

    pbwe_req_if  req_if ();
    pbwe_byte_if byte_if ();

    protobuf_wire_encoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_byte  (byte_if)
    );

    t_wire_byte        pending_bytes [$];
    logic [BYTE_W-1:0] enc_bytes [$];

    int n_fail    = 0;
    int n_req     = 0;
    int n_dropped = 0;
    int n_bytes   = 0;
    int op_hits [8] = '{default: 0};

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- expected byte stream ----------------

    function automatic void append_enc(logic [BYTE_W-1:0] b);
        enc_bytes.insert(enc_bytes.size(), b);
    endfunction

    function automatic void add_varint(logic [VAL_W-1:0] v);
        while (v > 64'h7F) begin
            append_enc({1'b1, v[6:0]});
            v = v >> GROUP_BITS;
        end
        append_enc(v[BYTE_W-1:0]);
    endfunction

    function automatic void commit_bytes();
        t_wire_byte w;
        foreach (enc_bytes[i]) begin
            w.data = enc_bytes[i];
            w.last = (i == enc_bytes.size() - 1);
            pending_bytes.insert(pending_bytes.size(), w);
        end
        enc_bytes.delete();
    endfunction

    function automatic void encode_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                           logic [FIELD_W-1:0] field, logic [WT_W-1:0] wt);
        case (op)
            OP_VARINT:  add_varint(value);
            OP_TAG:     add_varint(64'({field, wt}));
            OP_FIXED32: begin
                for (int i = 0; i < 4; i++) append_enc(value[8*i +: 8]);
            end
            OP_BOOL:    append_enc((value != 0) ? 8'd1 : 8'd0);
            OP_HEADER: begin
                add_varint(64'({field, WT_LEN_DELIM}));
                add_varint(value);
            end
            OP_RAW:     append_enc(value[BYTE_W-1:0]);
            default:    ;  // undefined opcodes emit nothing
        endcase
        commit_bytes();
    endfunction

    // ---------------- random helpers ----------------

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       v = v >> $urandom_range(0, 63);
            1:       v = 64'($urandom_range(0, 300));
            2:       v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            default: ;
        endcase
        return v;
    endfunction

    // ---------------- request side ----------------

    task automatic drive_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                 logic [FIELD_W-1:0] field, logic [WT_W-1:0] wt, int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.operation    <= op;
        req_if.item_value   <= value;
        req_if.field_number <= field;
        req_if.wire_kind    <= wt;
        req_if.valid        <= 1'b1;
        do @(posedge clk); while (!req_if.ready);
        n_req++;
        op_hits[op]++;
        if (op == OP_UNDEF_LO || op == OP_UNDEF_HI) n_dropped++;
    endtask

    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
    endtask

    initial begin
        logic [OP_W-1:0]    op;
        logic [VAL_W-1:0]   value;
        logic [FIELD_W-1:0] field;
        logic [WT_W-1:0]    wt;
        int                 n_rand;
        bit                 calm;
        bit                 paused;

        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.operation     = '0;
        req_if.item_value    = '0;
        req_if.field_number  = '0;
        req_if.wire_kind     = '0;
        n_rand = 0;
        calm   = 1'b0;
        paused = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            drive_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].field,
                          dir_rows[i].wt, next_gap());
            if (dir_rows[i].n_known == PREDICT) begin
                encode_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].field,
                               dir_rows[i].wt);
            end else begin
                for (int b = 0; b < dir_rows[i].n_known; b++)
                    append_enc(dir_rows[i].known[8*b +: 8]);
                commit_bytes();
            end
        end

        pause_until_drained();

        while (n_rand < N_RANDOM) begin
            if ($urandom_range(0, 99) < 6)
                op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            else
                op = 3'($urandom_range(0, 5));
            value = rand_value();
            if (op == OP_BOOL && $urandom_range(0, 1)) value = '0;
            field = 29'($urandom >> $urandom_range(0, 31));
            wt    = 3'($urandom_range(0, 7));

            if ($urandom_range(0, 9) == 0) calm = !calm;
            drive_request(op, value, field, wt, calm ? 0 : next_gap());
            encode_request(op, value, field, wt);
            if (op != OP_UNDEF_LO && op != OP_UNDEF_HI) n_rand++;

            // one full drain in the middle of the random run
            if (!paused && n_rand == N_RANDOM / 2) begin
                paused = 1'b1;
                pause_until_drained();
            end
        end

        req_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d encode requests sent (%0d with undefined opcodes), %0d wire bytes checked",
                 n_req, n_dropped, n_bytes);
        $display("per opcode: varint %0d, tag %0d, fixed32 %0d, bool %0d, header %0d, raw %0d",
                 op_hits[OP_VARINT], op_hits[OP_TAG], op_hits[OP_FIXED32],
                 op_hits[OP_BOOL], op_hits[OP_HEADER], op_hits[OP_RAW]);
        if (n_fail == 0)
            $display("protobuf_wire_encoder test passed");
        else
            $display("protobuf_wire_encoder test failed");
        $finish;
    end

    // ---------------- byte side ----------------

    initial begin
        int   stall_left;
        int   calm_left;
        int   r;
        logic rdy;

        stall_left    = 0;
        calm_left     = 0;
        byte_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                rdy = 1'b1;
            end else begin
                rdy = 1'b1;
                r   = $urandom_range(0, 99);
                if (r < 8) begin
                    calm_left = $urandom_range(20, 80);
                end else if (r < 35) begin
                    rdy        = 1'b0;
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25)
                                                              : $urandom_range(0, 2);
                end
            end
            byte_if.ready <= rdy;
        end
    end

    initial begin
        t_wire_byte w;
        forever begin
            @(posedge clk);
            if (rst_n && byte_if.valid && byte_if.ready) begin
                n_bytes++;
                if (pending_bytes.size() == 0) begin
                    n_fail++;
                    $error("out_byte: no byte expected, got %h (last_byte %b)",
                           byte_if.out_byte, byte_if.last_byte);
                end else begin
                    w = pending_bytes.pop_front();
                    if (byte_if.out_byte !== w.data) begin
                        n_fail++;
                        $error("out_byte: expected %h, got %h", w.data, byte_if.out_byte);
                    end
                    if (byte_if.last_byte !== w.last) begin
                        n_fail++;
                        $error("last_byte: expected %b, got %b", w.last, byte_if.last_byte);
                    end
                end
            end
        end
    end

    // stop a hung run: count cycles where neither channel moves
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (byte_if.valid && byte_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no request or byte moved for %0d cycles", IDLE_LIMIT);
        $display("protobuf_wire_encoder test failed");
        $finish;
    end

endmodule
